[rtl/dcsm_pkg.sv]
// ----------------------------------------------------------------------------
// dcsm_pkg
// Shared types, codes and constants of the DHCP client state machine unit.
// ----------------------------------------------------------------------------
package dcsm_pkg;

   // option area size after the fixed BOOTP header
   localparam int OPTION_AREA_BYTES = 312;

   localparam int OFFSET_W   = 10;
   localparam logic [OFFSET_W-1:0] OFFSET_MAX = 10'd1023;
   localparam logic [OFFSET_W-1:0] OPT_START  = 10'd240;
   localparam logic [OFFSET_W-1:0] MIN_LAST   = 10'd239;
   localparam int OPT_END_RAW = 240 + OPTION_AREA_BYTES;
   localparam logic [OFFSET_W-1:0] OPT_END =
      (OPT_END_RAW > 1023) ? OFFSET_MAX : OFFSET_W'(OPT_END_RAW);

   // request kinds
   localparam logic [1:0] KIND_DISCOVER = 2'd0;
   localparam logic [1:0] KIND_RELEASE  = 2'd1;
   localparam logic [1:0] KIND_REPLY    = 2'd2;

   // result actions
   localparam logic [2:0] ACT_SEND_DISCOVER = 3'd0;
   localparam logic [2:0] ACT_SEND_REQUEST  = 3'd1;
   localparam logic [2:0] ACT_SEND_RELEASE  = 3'd2;
   localparam logic [2:0] ACT_CONFIGURE     = 3'd3;
   localparam logic [2:0] ACT_REFUSED       = 3'd4;

   // client states
   localparam logic [2:0] ST_INIT       = 3'd0;
   localparam logic [2:0] ST_SELECTING  = 3'd1;
   localparam logic [2:0] ST_REQUESTING = 3'd2;
   localparam logic [2:0] ST_BOUND      = 3'd3;

   // option TLV parser phases
   localparam logic [1:0] TLV_TYPE  = 2'd0;
   localparam logic [1:0] TLV_LEN   = 2'd1;
   localparam logic [1:0] TLV_VALUE = 2'd2;

   // option codes
   localparam logic [7:0] OPT_PAD          = 8'd0;
   localparam logic [7:0] OPT_MASK         = 8'd1;
   localparam logic [7:0] OPT_ROUTER       = 8'd3;
   localparam logic [7:0] OPT_DNS          = 8'd6;
   localparam logic [7:0] OPT_LEASE        = 8'd51;
   localparam logic [7:0] OPT_MESSAGE_TYPE = 8'd53;
   localparam logic [7:0] OPT_SERVER       = 8'd54;
   localparam logic [7:0] OPT_END_CODE     = 8'd255;

   // message types and BOOTP op
   localparam logic [7:0] MSG_OFFER  = 8'd2;
   localparam logic [7:0] MSG_ACK    = 8'd5;
   localparam logic [7:0] MSG_NAK    = 8'd6;
   localparam logic [7:0] BOOT_REPLY = 8'd2;

   // transaction id generator
   localparam logic [31:0] LCG_MULT  = 32'd1103515245;
   localparam logic [31:0] LCG_INC   = 32'd12345;
   localparam logic [31:0] XID_RESET = 32'h12345678;
   localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] tx_xid;
      logic [31:0] dest_ip;
      logic [31:0] requested_ip;
      logic [31:0] server_id;
      logic [31:0] iface_addr;
      logic [31:0] iface_mask;
      logic [31:0] iface_gateway;
      logic [31:0] dns_addr;
      logic [31:0] lease_seconds;
      logic [2:0]  client_state;
   } rsp_type;

   // reply status seen at the current byte, before the end-of-datagram clear
   typedef struct packed {
      logic        header_ok;
      logic        long_enough;
      logic [7:0]  message_type;
      logic [31:0] your_addr;
   } rx_status_type;

   // option values after the current request
   typedef struct packed {
      logic [31:0] server_addr;
      logic [31:0] mask_value;
      logic [31:0] router_value;
      logic [31:0] dns_value;
      logic [31:0] lease_value;
   } store_type;

endpackage

[rtl/dcsm_if.sv]
// ----------------------------------------------------------------------------
// dcsm_if
// Request and response channel interfaces of the DHCP client unit.
// ----------------------------------------------------------------------------
interface dcsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] data_byte;
   logic       last;

   modport source (output valid, output kind, output data_byte, output last,
                   input ready);
   modport sink   (input valid, input kind, input data_byte, input last,
                   output ready);
endinterface

interface dcsm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] tx_xid;
   logic [31:0] dest_ip;
   logic [31:0] requested_ip;
   logic [31:0] server_id;
   logic [31:0] iface_addr;
   logic [31:0] iface_mask;
   logic [31:0] iface_gateway;
   logic [31:0] dns_addr;
   logic [31:0] lease_seconds;
   logic [2:0]  client_state;

   modport source (output valid, output action, output tx_xid, output dest_ip,
                   output requested_ip, output server_id, output iface_addr,
                   output iface_mask, output iface_gateway, output dns_addr,
                   output lease_seconds, output client_state, input ready);
   modport sink   (input valid, input action, input tx_xid, input dest_ip,
                   input requested_ip, input server_id, input iface_addr,
                   input iface_mask, input iface_gateway, input dns_addr,
                   input lease_seconds, input client_state, output ready);
endinterface

[rtl/dcsm_rx_parser.sv]
// ----------------------------------------------------------------------------
// dcsm_rx_parser
// Byte-at-a-time reply parser: header checks, yiaddr capture, option TLVs.
// ----------------------------------------------------------------------------
module dcsm_rx_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   byte_step,
   input  logic [7:0]             data_byte,
   input  logic                   last,
   input  logic [31:0]            current_xid,
   output dcsm_pkg::rx_status_type status,
   output dcsm_pkg::store_type     store
);
   import dcsm_pkg::*;

   logic [OFFSET_W-1:0] byte_offset_ff, byte_offset_in;
   logic                header_ok_ff, header_ok_in;
   logic [31:0]         your_addr_ff, your_addr_in;
   logic [1:0]          tlv_phase_ff, tlv_phase_in;
   logic [7:0]          option_code_ff, option_code_in;
   logic [7:0]          option_left_ff, option_left_in;
   logic [7:0]          option_len_ff, option_len_in;
   logic [31:0]         value_shift_ff, value_shift_in;
   logic [7:0]          message_type_ff, message_type_in;
   logic                options_ended_ff, options_ended_in;
   store_type           store_ff, store_in;

   logic                hok;
   logic [31:0]         yaddr;
   logic [7:0]          mtype;
   logic [7:0]          k;
   logic [31:0]         vs;
   logic [7:0]          xid_byte;

   always_comb begin
      byte_offset_in   = byte_offset_ff;
      header_ok_in     = header_ok_ff;
      your_addr_in     = your_addr_ff;
      tlv_phase_in     = tlv_phase_ff;
      option_code_in   = option_code_ff;
      option_left_in   = option_left_ff;
      option_len_in    = option_len_ff;
      value_shift_in   = value_shift_ff;
      message_type_in  = message_type_ff;
      options_ended_in = options_ended_ff;
      store_in         = store_ff;

      hok      = header_ok_ff;
      yaddr    = your_addr_ff;
      mtype    = message_type_ff;
      k        = option_len_ff - option_left_ff;
      vs       = value_shift_ff;
      xid_byte = 8'(current_xid >> {byte_offset_ff[1:0], 3'b000});

      if (byte_step) begin
         if (byte_offset_ff == 10'd0 && data_byte != BOOT_REPLY) begin
            hok = 1'b0;
         end
         if (byte_offset_ff >= 10'd4 && byte_offset_ff <= 10'd7 &&
             data_byte != xid_byte) begin
            hok = 1'b0;
         end
         // yiaddr, first wire byte in the low bits
         if (byte_offset_ff == 10'd16) begin
            yaddr = {24'd0, data_byte};
         end else if (byte_offset_ff >= 10'd17 && byte_offset_ff <= 10'd19) begin
            yaddr = your_addr_ff |
                    (32'(data_byte) << {byte_offset_ff[1:0], 3'b000});
         end

         if (hok && !options_ended_ff && byte_offset_ff >= OPT_START &&
             byte_offset_ff < OPT_END) begin
            case (tlv_phase_ff)
               TLV_TYPE: begin
                  if (data_byte == OPT_END_CODE) begin
                     options_ended_in = 1'b1;
                  end else if (data_byte != OPT_PAD) begin
                     option_code_in = data_byte;
                     tlv_phase_in   = TLV_LEN;
                  end
               end
               TLV_LEN: begin
                  option_left_in = data_byte;
                  option_len_in  = data_byte;
                  value_shift_in = 32'd0;
                  tlv_phase_in   = (data_byte == 8'd0) ? TLV_TYPE : TLV_VALUE;
               end
               default: begin
                  if (k == 8'd0 && option_code_ff == OPT_MESSAGE_TYPE) begin
                     mtype = data_byte;
                  end
                  if (k < 8'd4) begin
                     // lease is big-endian, addresses little-end first
                     if (option_code_ff == OPT_LEASE) begin
                        vs = {value_shift_ff[23:0], data_byte};
                     end else begin
                        vs = value_shift_ff | (32'(data_byte) << {k[1:0], 3'b000});
                     end
                     value_shift_in = vs;
                     if (k == 8'd3 && option_len_ff >= 8'd4) begin
                        case (option_code_ff)
                           OPT_MASK:   store_in.mask_value   = vs;
                           OPT_ROUTER: store_in.router_value = vs;
                           OPT_DNS:    store_in.dns_value    = vs;
                           OPT_LEASE:  store_in.lease_value  = vs;
                           OPT_SERVER: store_in.server_addr  = vs;
                           default: ;
                        endcase
                     end
                  end
                  option_left_in = option_left_ff - 8'd1;
                  if (option_left_in == 8'd0) begin
                     tlv_phase_in = TLV_TYPE;
                  end
               end
            endcase
         end

         header_ok_in    = hok;
         your_addr_in    = yaddr;
         message_type_in = mtype;

         if (!last) begin
            byte_offset_in = (byte_offset_ff < OFFSET_MAX) ?
                             byte_offset_ff + 10'd1 : OFFSET_MAX;
         end else begin
            byte_offset_in   = '0;
            header_ok_in     = 1'b1;
            your_addr_in     = '0;
            tlv_phase_in     = TLV_TYPE;
            option_code_in   = '0;
            option_left_in   = '0;
            option_len_in    = '0;
            value_shift_in   = '0;
            message_type_in  = '0;
            options_ended_in = 1'b0;
         end
      end
   end

   assign status.header_ok    = hok;
   assign status.long_enough  = (byte_offset_ff >= MIN_LAST);
   assign status.message_type = mtype;
   assign status.your_addr    = yaddr;
   assign store               = store_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_offset_ff   <= '0;
         header_ok_ff     <= 1'b1;
         your_addr_ff     <= '0;
         tlv_phase_ff     <= TLV_TYPE;
         option_code_ff   <= '0;
         option_left_ff   <= '0;
         option_len_ff    <= '0;
         value_shift_ff   <= '0;
         message_type_ff  <= '0;
         options_ended_ff <= 1'b0;
         store_ff         <= '0;
      end else begin
         byte_offset_ff   <= byte_offset_in;
         header_ok_ff     <= header_ok_in;
         your_addr_ff     <= your_addr_in;
         tlv_phase_ff     <= tlv_phase_in;
         option_code_ff   <= option_code_in;
         option_left_ff   <= option_left_in;
         option_len_ff    <= option_len_in;
         value_shift_ff   <= value_shift_in;
         message_type_ff  <= message_type_in;
         options_ended_ff <= options_ended_in;
         store_ff         <= store_in;
      end
   end

endmodule

[rtl/dcsm_ctrl.sv]
// ----------------------------------------------------------------------------
// dcsm_ctrl
// Client state machine, xid generator and result formatting.
// ----------------------------------------------------------------------------
module dcsm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    go,
   input  dcsm_pkg::req_type       req,
   input  dcsm_pkg::rx_status_type status,
   input  dcsm_pkg::store_type     store,
   output logic [31:0]             current_xid,
   output logic                    has_result,
   output dcsm_pkg::rsp_type       result
);
   import dcsm_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [31:0] xid_ff, xid_in;
   logic [31:0] gen_ff, gen_in;
   logic [31:0] assigned_ff, assigned_in;
   logic [31:0] lcg_next;
   logic [2:0]  act;
   logic        emit;
   logic        do_disc;

   assign lcg_next = gen_ff * LCG_MULT + LCG_INC;

   always_comb begin
      phase_in    = phase_ff;
      xid_in      = xid_ff;
      gen_in      = gen_ff;
      assigned_in = assigned_ff;
      act         = ACT_SEND_DISCOVER;
      emit        = 1'b0;
      do_disc     = 1'b0;

      if (go) begin
         case (req.kind)
            KIND_DISCOVER: do_disc = 1'b1;
            KIND_RELEASE: begin
               emit = 1'b1;
               if (phase_ff == ST_BOUND) begin
                  phase_in = ST_INIT;
                  act      = ACT_SEND_RELEASE;
               end else begin
                  act = ACT_REFUSED;
               end
            end
            KIND_REPLY: begin
               if (req.last && status.header_ok && status.long_enough) begin
                  if (phase_ff == ST_SELECTING && status.message_type == MSG_OFFER) begin
                     assigned_in = status.your_addr;
                     phase_in    = ST_REQUESTING;
                     act         = ACT_SEND_REQUEST;
                     emit        = 1'b1;
                  end else if (phase_ff == ST_REQUESTING &&
                               status.message_type == MSG_ACK) begin
                     phase_in = ST_BOUND;
                     act      = ACT_CONFIGURE;
                     emit     = 1'b1;
                  end else if (phase_ff == ST_REQUESTING &&
                               status.message_type == MSG_NAK) begin
                     do_disc = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end

      if (do_disc) begin
         gen_in   = lcg_next;
         xid_in   = lcg_next;
         phase_in = ST_SELECTING;
         act      = ACT_SEND_DISCOVER;
         emit     = 1'b1;
      end
   end

   always_comb begin
      result = '0;
      result.action = act;
      if (act <= ACT_SEND_RELEASE) begin
         result.tx_xid = xid_in;
      end
      if (act <= ACT_SEND_REQUEST) begin
         result.dest_ip = ALL_ONES;
      end
      if (act == ACT_SEND_RELEASE) begin
         result.dest_ip = store.server_addr;
      end
      if (act == ACT_SEND_REQUEST || act == ACT_SEND_RELEASE) begin
         result.requested_ip = assigned_in;
      end
      if (act == ACT_SEND_REQUEST) begin
         result.server_id = store.server_addr;
      end
      if (act == ACT_CONFIGURE) begin
         result.iface_addr    = assigned_in;
         result.iface_mask    = store.mask_value;
         result.iface_gateway = store.router_value;
      end
      result.dns_addr      = store.dns_value;
      result.lease_seconds = store.lease_value;
      result.client_state  = phase_in;
   end

   assign has_result  = emit;
   assign current_xid = xid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= ST_INIT;
         xid_ff      <= '0;
         gen_ff      <= XID_RESET;
         assigned_ff <= '0;
      end else begin
         phase_ff    <= phase_in;
         xid_ff      <= xid_in;
         gen_ff      <= gen_in;
         assigned_ff <= assigned_in;
      end
   end

endmodule

[rtl/dhcp_client_state_machine_unit.sv]
// ----------------------------------------------------------------------------
// dhcp_client_state_machine_unit
// DHCP client engine: commands and reply bytes in, send orders and
// interface settings out.
// ----------------------------------------------------------------------------
// One request is taken per clock when the result register is free or being
// drained; a request that produces a result passes the input register, then
// the parser and state update into the result register, before it is put on
// the result port. Reply bytes thus stream at one byte per clock while the
// result register is free or being drained. The path that sets the clock is
// the transaction id generator, one 32x32 truncated multiply-add, and the
// option parser update of one byte.
// ----------------------------------------------------------------------------
module dhcp_client_state_machine_unit (
   input  logic       clock,
   input  logic       reset,
   dcsm_req_if.sink   req_chan,
   dcsm_rsp_if.source rsp_chan
);
   import dcsm_pkg::*;

   logic          in_valid_ff, in_valid_in;
   req_type       in_data_ff;
   logic          out_valid_ff, out_valid_in;
   rsp_type       out_data_ff;
   logic          go;
   logic          has_result;
   rsp_type       result;
   rx_status_type status;
   store_type     store;
   logic [31:0]   current_xid;

   assign go             = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || go;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
      end
      out_valid_in = out_valid_ff;
      if (go) begin
         out_valid_in = has_result;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_data_ff.kind      <= req_chan.kind;
         in_data_ff.data_byte <= req_chan.data_byte;
         in_data_ff.last      <= req_chan.last;
      end
      if (go && has_result) begin
         out_data_ff <= result;
      end
   end

   dcsm_rx_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .byte_step   (go && in_data_ff.kind == KIND_REPLY),
      .data_byte   (in_data_ff.data_byte),
      .last        (in_data_ff.last),
      .current_xid (current_xid),
      .status      (status),
      .store       (store)
   );

   dcsm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .go          (go),
      .req         (in_data_ff),
      .status      (status),
      .store       (store),
      .current_xid (current_xid),
      .has_result  (has_result),
      .result      (result)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.action        = out_data_ff.action;
   assign rsp_chan.tx_xid        = out_data_ff.tx_xid;
   assign rsp_chan.dest_ip       = out_data_ff.dest_ip;
   assign rsp_chan.requested_ip  = out_data_ff.requested_ip;
   assign rsp_chan.server_id     = out_data_ff.server_id;
   assign rsp_chan.iface_addr    = out_data_ff.iface_addr;
   assign rsp_chan.iface_mask    = out_data_ff.iface_mask;
   assign rsp_chan.iface_gateway = out_data_ff.iface_gateway;
   assign rsp_chan.dns_addr      = out_data_ff.dns_addr;
   assign rsp_chan.lease_seconds = out_data_ff.lease_seconds;
   assign rsp_chan.client_state  = out_data_ff.client_state;

   // a processed discover always leaves a result behind
   a_discover_result : assert property (@(posedge clock) disable iff (reset)
      go && in_data_ff.kind == KIND_DISCOVER |=> out_valid_ff)
      else $error("discover produced no result");

   a_discover_state : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.action == ACT_SEND_DISCOVER |->
         out_data_ff.dest_ip == ALL_ONES && out_data_ff.client_state == ST_SELECTING)
      else $error("discover result inconsistent");

   a_request_state : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.action == ACT_SEND_REQUEST |->
         out_data_ff.client_state == ST_REQUESTING)
      else $error("request result not in requesting");

   a_bound_state : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.action == ACT_CONFIGURE |->
         out_data_ff.client_state == ST_BOUND)
      else $error("configure result not in bound");

   a_refused_state : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.action == ACT_REFUSED |->
         out_data_ff.client_state != ST_BOUND)
      else $error("release refused while bound");

endmodule

[tb/sv/dhcp_client_state_machine_unit_test.sv]
// ----------------------------------------------------------------------------
// dhcp_client_state_machine_unit_test
// Self-checking bench for the DHCP client unit: a table of directed requests
// (commands, good and broken replies, long and truncated datagrams), then
// random DISCOVER/OFFER/ACK/NAK/RELEASE exchanges mixed with noise, all
// checked field by field against a cycle-free model of the client.
// ----------------------------------------------------------------------------
module dhcp_client_state_machine_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import dcsm_pkg::*;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 6;
   localparam int CYCLE_LIMIT    = 2_000_000;
   localparam int SETTLE_CYCLES  = 16;
   localparam int RANDOM_ITEMS   = 850;
   localparam int MAX_GAP        = 18;
   localparam int PRINT_LIMIT    = 40;

   localparam logic [1:0] KIND_IGNORED = 2'd3;

   // datagram shapes
   localparam logic [2:0] SHAPE_TIDY    = 3'd0;
   localparam logic [2:0] SHAPE_CUT     = 3'd1;
   localparam logic [2:0] SHAPE_CUT_HDR = 3'd2;
   localparam logic [2:0] SHAPE_BARE    = 3'd3;
   localparam logic [2:0] SHAPE_LONG    = 3'd4;
   localparam logic [2:0] SHAPE_NOISY   = 3'd5;

   localparam rsp_type REFUSED_AT_RESET =
      '{action: ACT_REFUSED, client_state: ST_INIT, default: '0};

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] cmd_byte;
      logic       cmd_last;
      logic [7:0] bootp_op;
      logic       xid_good;
      logic [7:0] reply_type;
      logic [2:0] shape;
      logic       mid_release;
      logic       lit_refused;
   } plan_row_type;

   localparam int PLAN_ROWS = 23;

   logic clock = 1'b0;
   logic reset;

   dcsm_req_if req_chan ();
   dcsm_rsp_if rsp_chan ();

   dhcp_client_state_machine_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #(HALF_PERIOD) clock = 1'b1;
      #(HALF_PERIOD) clock = 1'b0;
   end

   // client model state
   logic [2:0]  cl_phase;
   logic [31:0] cl_xid, xid_gen, lease_addr, srv_addr, net_mask, gw_addr;
   logic [31:0] dns_srv, lease_secs;
   // reply parser state
   logic [9:0]  rx_off;
   logic        rx_hdr_ok;
   logic [31:0] rx_yaddr;
   logic [1:0]  tlv_st;
   logic [7:0]  opt_code, opt_left, opt_len;
   logic [31:0] opt_val;
   logic [7:0]  rx_mtype;
   logic        opts_done;

   rsp_type      pending_rsp_q[$];
   logic [7:0]   dgram[$];
   plan_row_type plan [PLAN_ROWS];

   int cycle_count, err_count, sent_items, predicted_results, checked_results;
   int dgram_count, bound_seen, release_seen, refused_seen;
   int tx_quiet, rx_quiet, rx_hold;
   bit paused_once = 1'b0;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  pending_rsp_q.size());
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- model
   function automatic void clear_rx();
      rx_off      = '0;
      rx_hdr_ok   = 1'b1;
      rx_yaddr    = '0;
      tlv_st      = TLV_TYPE;
      opt_code    = '0;
      opt_left    = '0;
      opt_len     = '0;
      opt_val     = '0;
      rx_mtype    = '0;
      opts_done   = 1'b0;
   endfunction

   function automatic void reset_client();
      cl_phase   = ST_INIT;
      cl_xid     = '0;
      xid_gen    = XID_RESET;
      lease_addr = '0;
      srv_addr   = '0;
      net_mask   = '0;
      gw_addr    = '0;
      dns_srv    = '0;
      lease_secs = '0;
      clear_rx();
   endfunction

   function automatic rsp_type form_result(input logic [2:0] act);
      rsp_type r;
      r = '0;
      r.action = act;
      if (act inside {ACT_SEND_DISCOVER, ACT_SEND_REQUEST, ACT_SEND_RELEASE})
         r.tx_xid = cl_xid;
      if (act inside {ACT_SEND_DISCOVER, ACT_SEND_REQUEST}) r.dest_ip = ALL_ONES;
      if (act == ACT_SEND_RELEASE) r.dest_ip = srv_addr;
      if (act inside {ACT_SEND_REQUEST, ACT_SEND_RELEASE}) r.requested_ip = lease_addr;
      if (act == ACT_SEND_REQUEST) r.server_id = srv_addr;
      if (act == ACT_CONFIGURE) begin
         r.iface_addr    = lease_addr;
         r.iface_mask    = net_mask;
         r.iface_gateway = gw_addr;
      end
      r.dns_addr      = dns_srv;
      r.lease_seconds = lease_secs;
      r.client_state  = cl_phase;
      return r;
   endfunction

   function automatic rsp_type start_discover();
      xid_gen  = xid_gen * LCG_MULT + LCG_INC;
      cl_xid   = xid_gen;
      cl_phase = ST_SELECTING;
      return form_result(ACT_SEND_DISCOVER);
   endfunction

   function automatic void parse_option(input logic [7:0] b);
      logic [7:0] k;
      case (tlv_st)
         TLV_TYPE: begin
            if (b == OPT_END_CODE) opts_done = 1'b1;
            else if (b != OPT_PAD) begin
               opt_code = b;
               tlv_st   = TLV_LEN;
            end
         end
         TLV_LEN: begin
            opt_left = b;
            opt_len  = b;
            opt_val  = '0;
            tlv_st   = (b == 8'd0) ? TLV_TYPE : TLV_VALUE;
         end
         default: begin
            k = opt_len - opt_left;
            if (k == 8'd0 && opt_code == OPT_MESSAGE_TYPE) rx_mtype = b;
            if (k < 8'd4) begin
               // lease is big-endian, addresses keep the first byte low
               if (opt_code == OPT_LEASE) opt_val = {opt_val[23:0], b};
               else opt_val |= 32'(b) << (8 * k);
               if (k == 8'd3 && opt_len >= 8'd4) begin
                  case (opt_code)
                     OPT_MASK:   net_mask   = opt_val;
                     OPT_ROUTER: gw_addr    = opt_val;
                     OPT_DNS:    dns_srv    = opt_val;
                     OPT_LEASE:  lease_secs = opt_val;
                     OPT_SERVER: srv_addr   = opt_val;
                     default: ;
                  endcase
               end
            end
            opt_left = opt_left - 8'd1;
            if (opt_left == 8'd0) tlv_st = TLV_TYPE;
         end
      endcase
   endfunction

   function automatic bit take_reply_byte(input logic [7:0] b, input logic fin,
                                          output rsp_type r);
      int pos;
      bit got;
      pos = int'(rx_off);
      got = 1'b0;
      r   = '0;
      if (pos == 0 && b != BOOT_REPLY) rx_hdr_ok = 1'b0;
      if (pos >= 4 && pos <= 7 && b != cl_xid[8*(pos-4) +: 8]) rx_hdr_ok = 1'b0;
      if (pos == 16) rx_yaddr = 32'(b);
      else if (pos >= 17 && pos <= 19) rx_yaddr |= 32'(b) << (8 * (pos - 16));
      if (rx_hdr_ok && !opts_done && rx_off >= OPT_START && rx_off < OPT_END)
         parse_option(b);
      if (!fin) begin
         rx_off = (rx_off < OFFSET_MAX) ? rx_off + 10'd1 : OFFSET_MAX;
         return 1'b0;
      end
      if (rx_hdr_ok && rx_off >= MIN_LAST) begin
         if (cl_phase == ST_SELECTING && rx_mtype == MSG_OFFER) begin
            lease_addr = rx_yaddr;
            cl_phase   = ST_REQUESTING;
            r   = form_result(ACT_SEND_REQUEST);
            got = 1'b1;
         end else if (cl_phase == ST_REQUESTING && rx_mtype == MSG_ACK) begin
            cl_phase = ST_BOUND;
            r   = form_result(ACT_CONFIGURE);
            got = 1'b1;
         end else if (cl_phase == ST_REQUESTING && rx_mtype == MSG_NAK) begin
            cl_phase = ST_INIT;
            r   = start_discover();
            got = 1'b1;
         end
      end
      clear_rx();
      return got;
   endfunction

   function automatic bit predict_client(input logic [1:0] k, input logic [7:0] b,
                                         input logic fin, output rsp_type r);
      bit got;
      got = 1'b0;
      r   = '0;
      case (k)
         KIND_DISCOVER: begin
            r   = start_discover();
            got = 1'b1;
         end
         KIND_RELEASE: begin
            if (cl_phase == ST_BOUND) begin
               cl_phase = ST_INIT;
               r = form_result(ACT_SEND_RELEASE);
            end else r = form_result(ACT_REFUSED);
            got = 1'b1;
         end
         KIND_REPLY: got = take_reply_byte(b, fin, r);
         default: ;
      endcase
      return got;
   endfunction

   // ------------------------------------------------------------- stimulus
   function automatic int draw_gap(inout int quiet);
      if (quiet > 0) begin
         quiet--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         quiet = $urandom_range(16, 160);
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_item(input logic [1:0] k, input logic [7:0] b, input logic l,
                            input bit lit, input rsp_type lit_rsp);
      int gap;
      rsp_type p;
      bit got;
      gap = draw_gap(tx_quiet);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.kind      <= k;
      req_chan.data_byte <= b;
      req_chan.last      <= l;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      got = predict_client(k, b, l, p);
      if (lit) pending_rsp_q.push_back(lit_rsp);
      else if (got) pending_rsp_q.push_back(p);
      if (lit || got) predicted_results++;
      sent_items++;
   endtask

   task automatic send_command(input logic [1:0] k);
      send_item(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b0, '0);
   endtask

   // a command can be slipped in just before byte mid_at; -1 means none
   task automatic send_dgram(input logic [1:0] mid_kind, input int mid_at);
      int n;
      n = dgram.size();
      for (int i = 0; i < n; i++) begin
         if (i == mid_at) send_command(mid_kind);
         send_item(KIND_REPLY, dgram[i], i == n - 1, 1'b0, '0);
      end
      dgram_count++;
   endtask

   task automatic push_opt(input logic [7:0] code, input int len);
      dgram.push_back(code);
      dgram.push_back(8'(len));
      repeat (len) dgram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_tidy_options(input logic [7:0] mtype);
      logic [7:0] addr_opts [5];
      int len;
      addr_opts = '{OPT_SERVER, OPT_MASK, OPT_ROUTER, OPT_DNS, OPT_LEASE};
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(2, 3) : 1;
      dgram.push_back(OPT_MESSAGE_TYPE);
      dgram.push_back(8'(len));
      dgram.push_back(mtype);
      repeat (len - 1) dgram.push_back(8'($urandom_range(0, 255)));
      foreach (addr_opts[i]) begin
         if ($urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 5) == 0)
               repeat ($urandom_range(1, 3)) dgram.push_back(OPT_PAD);
            push_opt(addr_opts[i], ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8) : 4);
         end
      end
      if ($urandom_range(0, 3) == 0) push_opt(8'($urandom_range(7, 50)), $urandom_range(0, 10));
      if ($urandom_range(0, 7) != 0) dgram.push_back(OPT_END_CODE);
      repeat ($urandom_range(0, 16)) dgram.push_back(8'($urandom_range(0, 255)));
   endtask

   task automatic add_noisy_options(input logic [7:0] mtype);
      logic [7:0] codes [7];
      logic [7:0] code;
      int len;
      codes = '{OPT_MASK, OPT_ROUTER, OPT_DNS, OPT_LEASE, OPT_MESSAGE_TYPE, OPT_SERVER,
                8'd0};
      repeat ($urandom_range(1, 12)) begin
         case ($urandom_range(0, 9))
            0: dgram.push_back(OPT_PAD);
            1: dgram.push_back(OPT_END_CODE);
            default: begin
               code = codes[$urandom_range(0, 6)];
               if (code == 8'd0) code = 8'($urandom_range(1, 254));
               len = $urandom_range(0, 8);
               push_opt(code, len);
               if (code == OPT_MESSAGE_TYPE && len > 0 && $urandom_range(0, 3) != 0)
                  dgram[dgram.size() - len] = mtype;
            end
         endcase
      end
   endtask

   task automatic build_reply(input logic [7:0] op, input logic [31:0] xid,
                              input logic [7:0] mtype, input logic [2:0] shape);
      int n;
      dgram.delete();
      repeat (OPT_START) dgram.push_back(8'($urandom_range(0, 255)));
      dgram[0] = op;
      for (int i = 0; i < 4; i++) dgram[4 + i] = xid[8*i +: 8];
      case (shape)
         SHAPE_TIDY: add_tidy_options(mtype);
         SHAPE_CUT: begin
            add_tidy_options(mtype);
            if (dgram.size() > 242) begin
               n = $urandom_range(241, dgram.size() - 1);
               dgram = dgram[0:n-1];
            end
         end
         SHAPE_CUT_HDR: dgram = dgram[0:238];
         SHAPE_LONG: begin
            // pads run up to the end of the option area so options straddle it
            n = $urandom_range(536, 552);
            while (dgram.size() < n) dgram.push_back(OPT_PAD);
            add_tidy_options(mtype);
            n = $urandom_range(1030, 1100);
            while (dgram.size() < n) dgram.push_back(8'($urandom_range(0, 255)));
         end
         SHAPE_NOISY: begin
            add_noisy_options(mtype);
            n = $urandom_range(230, 330);
            while (dgram.size() < n) dgram.push_back(8'($urandom_range(0, 255)));
            dgram = dgram[0:n-1];
         end
         default: ;
      endcase
   endtask

   function automatic logic [7:0] pick_type();
      case ($urandom_range(0, 9))
         0, 1, 2: return MSG_OFFER;
         3, 4, 5: return MSG_ACK;
         6, 7:    return MSG_NAK;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic random_reply(input logic [7:0] mtype);
      int pick;
      logic [7:0] op;
      logic [31:0] xid;
      logic [2:0] shape;
      logic [1:0] mid;
      op  = ($urandom_range(0, 24) == 0) ? 8'($urandom_range(0, 255)) : BOOT_REPLY;
      xid = cl_xid;
      if ($urandom_range(0, 19) == 0) xid ^= 32'h1 << $urandom_range(0, 31);
      pick = $urandom_range(0, 99);
      if (pick < 72)      shape = SHAPE_TIDY;
      else if (pick < 82) shape = SHAPE_CUT;
      else if (pick < 90) shape = SHAPE_NOISY;
      else if (pick < 94) shape = SHAPE_LONG;
      else if (pick < 97) shape = SHAPE_BARE;
      else                shape = SHAPE_CUT_HDR;
      build_reply(op, xid, mtype, shape);
      if ($urandom_range(0, 9) == 0) begin
         mid = 2'($urandom_range(0, 2));
         if (mid == KIND_REPLY) mid = KIND_IGNORED;
         send_dgram(mid, $urandom_range(0, dgram.size() - 1));
      end else send_dgram(KIND_IGNORED, -1);
   endtask

   task automatic wait_all_results();
      req_chan.valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------- checking
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      if (err_count <= PRINT_LIMIT)
         $display("mismatch at cycle %0d: %s got 0x%08h want 0x%08h", cycle_count, what,
                  got, want);
   endtask

   task automatic check_result(input rsp_type got, input rsp_type want);
      if (got.action != want.action)
         report_mismatch("action", 32'(got.action), 32'(want.action));
      if (got.tx_xid != want.tx_xid) report_mismatch("tx_xid", got.tx_xid, want.tx_xid);
      if (got.dest_ip != want.dest_ip) report_mismatch("dest_ip", got.dest_ip, want.dest_ip);
      if (got.requested_ip != want.requested_ip)
         report_mismatch("requested_ip", got.requested_ip, want.requested_ip);
      if (got.server_id != want.server_id)
         report_mismatch("server_id", got.server_id, want.server_id);
      if (got.iface_addr != want.iface_addr)
         report_mismatch("iface_addr", got.iface_addr, want.iface_addr);
      if (got.iface_mask != want.iface_mask)
         report_mismatch("iface_mask", got.iface_mask, want.iface_mask);
      if (got.iface_gateway != want.iface_gateway)
         report_mismatch("iface_gateway", got.iface_gateway, want.iface_gateway);
      if (got.dns_addr != want.dns_addr) report_mismatch("dns_addr", got.dns_addr, want.dns_addr);
      if (got.lease_seconds != want.lease_seconds)
         report_mismatch("lease_seconds", got.lease_seconds, want.lease_seconds);
      if (got.client_state != want.client_state)
         report_mismatch("client_state", 32'(got.client_state), 32'(want.client_state));
   endtask

   // result side: sample at the edge, stall a random number of cycles per result
   initial begin
      rsp_type got;
      rsp_chan.ready = 1'b0;
      rx_hold = 0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_chan.valid && rsp_chan.ready) begin
               got = {rsp_chan.action, rsp_chan.tx_xid, rsp_chan.dest_ip,
                      rsp_chan.requested_ip, rsp_chan.server_id, rsp_chan.iface_addr,
                      rsp_chan.iface_mask, rsp_chan.iface_gateway, rsp_chan.dns_addr,
                      rsp_chan.lease_seconds, rsp_chan.client_state};
               if (pending_rsp_q.size() == 0)
                  report_mismatch("unexpected result", 32'(got.action), 32'd0);
               else check_result(got, pending_rsp_q.pop_front());
               checked_results++;
               if (got.action == ACT_CONFIGURE) bound_seen++;
               if (got.action == ACT_SEND_RELEASE) release_seen++;
               if (got.action == ACT_REFUSED) refused_seen++;
               rx_hold = draw_gap(rx_quiet);
            end
            if (rx_hold > 0) begin
               rsp_chan.ready <= 1'b0;
               rx_hold--;
            end else rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------ main flow
   initial begin
      int base_items, pick;
      req_chan.valid     = 1'b0;
      req_chan.kind      = KIND_DISCOVER;
      req_chan.data_byte = '0;
      req_chan.last      = 1'b0;
      reset = 1'b1;
      reset_client();

      plan = '{
         '{KIND_RELEASE,  8'h00, 1'b0, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b1},
         '{KIND_IGNORED,  8'hFF, 1'b1, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_DISCOVER, 8'hFF, 1'b1, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, 8'h01,      1'b1, MSG_OFFER, SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b0, MSG_OFFER, SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_CUT_HDR, 1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_CUT,     1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_BARE,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_ACK,   SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_DISCOVER, 8'h00, 1'b0, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_RELEASE,  8'h55, 1'b1, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_NAK,   SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_TIDY,    1'b1, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_ACK,   SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_LONG,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_ACK,   SHAPE_NOISY,   1'b0, 1'b0},
         '{KIND_RELEASE,  8'hAA, 1'b0, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_RELEASE,  8'hFF, 1'b1, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_DISCOVER, 8'h00, 1'b0, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0},
         '{KIND_REPLY,    8'h00, 1'b0, BOOT_REPLY, 1'b1, MSG_OFFER, SHAPE_LONG,    1'b0, 1'b0},
         '{KIND_IGNORED,  8'h00, 1'b0, BOOT_REPLY, 1'b1, 8'h00,     SHAPE_TIDY,    1'b0, 1'b0}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == KIND_REPLY) begin
            build_reply(plan[i].bootp_op, plan[i].xid_good ? cl_xid : ~cl_xid,
                        plan[i].reply_type, plan[i].shape);
            if (plan[i].mid_release)
               send_dgram(KIND_RELEASE, $urandom_range(8, dgram.size() - 2));
            else send_dgram(KIND_IGNORED, -1);
         end else begin
            send_item(plan[i].kind, plan[i].cmd_byte, plan[i].cmd_last, plan[i].lit_refused,
                      REFUSED_AT_RESET);
         end
      end
      wait_all_results();

      base_items = sent_items;
      while (sent_items - base_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            // one full lease exchange, occasionally broken along the way
            send_command(KIND_DISCOVER);
            random_reply(($urandom_range(0, 9) != 0) ? MSG_OFFER : pick_type());
            random_reply(($urandom_range(0, 9) < 7) ? MSG_ACK : pick_type());
            if ($urandom_range(0, 1) == 0) send_command(KIND_RELEASE);
         end else if (pick < 80) begin
            send_command(2'($urandom_range(0, 3)));
         end else begin
            random_reply(pick_type());
         end
         if (!paused_once && sent_items - base_items >= RANDOM_ITEMS / 2) begin
            paused_once = 1'b1;
            wait_all_results();
         end
      end

      wait_all_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d requests in %0d datagrams, %0d of %0d expected results checked",
               sent_items, dgram_count, checked_results, predicted_results);
      $display("leases bound %0d times, %0d releases sent, %0d releases refused", bound_seen,
               release_seen, refused_seen);
      if (err_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
